### hw/rtl/lpfs_pkg.sv
// Shared constants for the load-proportional frequency selector.
// No dependencies; used by the core and by its port checker.
`timescale 1ns / 1ps

package lpfs_pkg;

    // Operating-point table
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int FREQ_W  = 22;
    localparam int IDX_W   = 4;
    localparam int LOAD_W  = 7;
    localparam int LEN_W   = 5;
    localparam int CFG_IDX_W = 2;

    // Stream packing
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    // Load scale: divide the ceiling by PERCENT through a reciprocal multiply
    localparam int PERCENT     = 100;
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 24;
    localparam int QUOT_W      = 16;
    localparam int PROD_W      = FREQ_W + RECIP_W;
    localparam int RAW_W       = LOAD_W + QUOT_W;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'(((1 << RECIP_SHIFT) + PERCENT - 1) / PERCENT);
    localparam logic [LOAD_W-1:0] LOAD_MAX = LOAD_W'(PERCENT);

    // Item kinds carried on s_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CEIL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN = 2'd2;

    // Result bit positions in m_tdata
    localparam int OUT_CHANGE_BIT = FREQ_W;

endpackage

### hw/rtl/load_proportional_freq_select_core.sv
// Load-proportional frequency selector core: operating-point table memory,
// scale/clamp sequencer and table walk. Depends on lpfs_pkg.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one beat is one item. s_tuser selects the kind: 0 writes a
//   table entry (entry_index, entry_freq, entry_valid), 1 evaluates a load
//   sample (load, current_freq). A write beat yields no result beat; an
//   evaluate beat yields exactly one m_ beat with the target and
//   change_request.
//   cfg_ channel: register writes (0 floor, 1 ceiling, 2 table_length),
//   always ready; write only while the block is idle.
//   A write beat is stored at its accept edge and s_tready stays high.
//   An evaluate beat runs the setup steps (reciprocal multiply for
//   ceiling/100, load multiply, clamp), then walks up to n table entries,
//   where n is min(table_length, 16), stopping early at the first valid
//   entry at or above the clamped request, then loads the output register.
//   The walk uses the single read port of the table memory, whose read
//   data is registered. One evaluation runs at a time.
//   Reset (aresetn low, synchronous) clears the sequencer, the output
//   valid, all entry valid marks and the registers to their defaults.
//   Stall: a waiting result sits in the output register; write beats are
//   still taken meanwhile, and the next evaluation holds in its last step
//   until the output register is free.

module load_proportional_freq_select_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: entry_index[3:0], entry_freq[25:4], entry_valid[26],
    //          load[33:27], current_freq[55:34]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lpfs_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: mode[0]
    input  logic                            s_tuser,
    // m_tdata: target[21:0], change_request[22], zero pad[23]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lpfs_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lpfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpfs_pkg::FREQ_W-1:0]     cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_CLAMP = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    // Unpack the input beat
    logic [lpfs_pkg::IDX_W-1:0]  in_idx;
    logic [lpfs_pkg::FREQ_W-1:0] in_efreq;
    logic                        in_evalid;
    logic [lpfs_pkg::LOAD_W-1:0] in_load;
    logic [lpfs_pkg::FREQ_W-1:0] in_cur;

    assign in_idx    = s_tdata[3:0];
    assign in_efreq  = s_tdata[25:4];
    assign in_evalid = s_tdata[26];
    assign in_load   = s_tdata[33:27];
    assign in_cur    = s_tdata[55:34];

    // Configuration registers
    logic [lpfs_pkg::FREQ_W-1:0] floor_khz_reg;
    logic [lpfs_pkg::FREQ_W-1:0] ceil_khz_reg;
    logic [lpfs_pkg::LEN_W-1:0]  table_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_khz_reg <= '0;
            ceil_khz_reg  <= '1;
            table_len_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lpfs_pkg::REG_FLOOR:     floor_khz_reg <= cfg_data;
                lpfs_pkg::REG_CEIL:      ceil_khz_reg  <= cfg_data;
                lpfs_pkg::REG_TABLE_LEN: table_len_reg <= cfg_data[lpfs_pkg::LEN_W-1:0];
                default: ;  // index beyond the list: drop
            endcase
        end
    end

    // Sequencer and datapath registers
    logic [2:0]                        state_reg, state_next;
    logic [lpfs_pkg::LOAD_W-1:0]       load_reg, load_next;
    logic [lpfs_pkg::FREQ_W-1:0]       cur_reg, cur_next;
    logic [lpfs_pkg::CNT_W-1:0]        n_reg, n_next;
    logic [lpfs_pkg::CNT_W-1:0]        rd_cnt_reg, rd_cnt_next;
    logic                              pend_reg, pend_next;
    logic [lpfs_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [lpfs_pkg::RAW_W-1:0]        raw_reg, raw_next;
    logic [lpfs_pkg::FREQ_W-1:0]       req_reg, req_next;
    logic [lpfs_pkg::FREQ_W-1:0]       lower_reg, lower_next;
    logic [lpfs_pkg::FREQ_W-1:0]       upper_reg, upper_next;
    logic                              found_reg, found_next;
    logic                              m_valid_reg, m_valid_next;
    logic [lpfs_pkg::FREQ_W-1:0]       m_target_reg, m_target_next;
    logic                              m_change_reg, m_change_next;

    // Table memory and valid marks
    logic [lpfs_pkg::FREQ_W-1:0] freq_mem [lpfs_pkg::TABLE_DEPTH];
    logic [lpfs_pkg::TABLE_DEPTH-1:0] entry_ok_reg;
    logic [lpfs_pkg::FREQ_W-1:0] rd_data_reg;
    logic                        rd_ok_reg;

    logic                        s_accept;
    logic                        wr_en;
    logic                        rd_en;
    logic [lpfs_pkg::ADDR_W-1:0] rd_addr;
    logic [lpfs_pkg::ADDR_W-1:0] wr_addr;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign wr_en    = s_accept && (s_tuser == lpfs_pkg::MODE_WRITE)
                      && (32'(in_idx) < lpfs_pkg::TABLE_DEPTH);
    assign wr_addr  = lpfs_pkg::ADDR_W'(in_idx);
    assign rd_en    = (state_reg == ST_WALK) && (rd_cnt_reg < n_reg);
    assign rd_addr  = rd_cnt_reg[lpfs_pkg::ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            freq_mem[wr_addr] <= in_efreq;
        end
        if (rd_en) begin
            rd_data_reg <= freq_mem[rd_addr];
            rd_ok_reg   <= entry_ok_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_ok_reg <= '0;
        end else if (wr_en) begin
            entry_ok_reg[wr_addr] <= in_evalid;
        end
    end

    // Walk compare on the entry read in the previous cycle
    logic hit;
    logic stop;
    logic [lpfs_pkg::FREQ_W-1:0] raw_min;
    logic [lpfs_pkg::FREQ_W-1:0] final_target;

    assign hit  = pend_reg && rd_ok_reg;
    assign stop = hit && (rd_data_reg >= req_reg);

    always_comb begin
        // floor clamp first, then ceiling clamp, so the ceiling wins when
        // the floor lies above it
        raw_min = (raw_reg < lpfs_pkg::RAW_W'(floor_khz_reg)) ? floor_khz_reg
                                                              : lpfs_pkg::FREQ_W'(raw_reg);
        if (raw_reg < lpfs_pkg::RAW_W'(floor_khz_reg)) begin
            raw_min = floor_khz_reg;
        end else if (raw_reg > lpfs_pkg::RAW_W'(ceil_khz_reg)) begin
            raw_min = ceil_khz_reg;
        end
        if (raw_min > ceil_khz_reg) begin
            raw_min = ceil_khz_reg;
        end
    end

    always_comb begin
        priority if (found_reg) begin
            final_target = upper_reg;
        end else if (cur_reg >= lower_reg && cur_reg <= upper_reg) begin
            final_target = cur_reg;
        end else begin
            final_target = upper_reg;
        end
    end

    always_comb begin
        state_next    = state_reg;
        load_next     = load_reg;
        cur_next      = cur_reg;
        n_next        = n_reg;
        rd_cnt_next   = rd_cnt_reg;
        pend_next     = pend_reg;
        prod_next     = prod_reg;
        raw_next      = raw_reg;
        req_next      = req_reg;
        lower_next    = lower_reg;
        upper_next    = upper_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg;
        m_target_next = m_target_reg;
        m_change_next = m_change_reg;

        // Retire the waiting result
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == lpfs_pkg::MODE_EVAL)) begin
                    // saturate load above one hundred
                    load_next   = (in_load > lpfs_pkg::LOAD_MAX) ? lpfs_pkg::LOAD_MAX : in_load;
                    cur_next    = in_cur;
                    n_next      = (32'(table_len_reg) > lpfs_pkg::TABLE_DEPTH)
                                  ? lpfs_pkg::CNT_W'(lpfs_pkg::TABLE_DEPTH)
                                  : lpfs_pkg::CNT_W'(table_len_reg);
                    rd_cnt_next = '0;
                    pend_next   = 1'b0;
                    lower_next  = '0;
                    upper_next  = '0;
                    found_next  = 1'b0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                prod_next  = lpfs_pkg::PROD_W'(ceil_khz_reg) * lpfs_pkg::PROD_W'(lpfs_pkg::RECIP_MUL);
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                raw_next   = lpfs_pkg::RAW_W'(load_reg)
                             * lpfs_pkg::RAW_W'(prod_reg[lpfs_pkg::RECIP_SHIFT +: lpfs_pkg::QUOT_W]);
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                req_next   = raw_min;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                // issue the next read and evaluate the one that just returned
                pend_next = rd_en;
                if (rd_en) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (hit) begin
                    priority if (rd_data_reg < req_reg) begin
                        lower_next = rd_data_reg;
                    end else if (rd_data_reg == req_reg) begin
                        upper_next = rd_data_reg;
                        found_next = 1'b1;
                    end else begin
                        upper_next = rd_data_reg;
                    end
                end
                // hit >= request, or no read left (last entry seen now)
                if (stop || !rd_en) begin
                    pend_next  = 1'b0;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_target_next = final_target;
                    m_change_next = (final_target != '0) && (final_target != cur_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        load_reg     <= load_next;
        cur_reg      <= cur_next;
        n_reg        <= n_next;
        rd_cnt_reg   <= rd_cnt_next;
        prod_reg     <= prod_next;
        raw_reg      <= raw_next;
        req_reg      <= req_next;
        lower_reg    <= lower_next;
        upper_reg    <= upper_next;
        found_reg    <= found_next;
        m_target_reg <= m_target_next;
        m_change_reg <= m_change_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_change_reg, m_target_reg};

endmodule

### hw/rtl/lpfs_checker.sv
// Port-level checker for load_proportional_freq_select_core, bound into it.
// Depends on lpfs_pkg.
`timescale 1ns / 1ps

module lpfs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lpfs_pkg::M_DATA_W-1:0] m_tdata
);

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A change is never requested toward a zero target
    a_change_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[lpfs_pkg::OUT_CHANGE_BIT] |-> m_tdata[lpfs_pkg::FREQ_W-1:0] != '0)
        else $error("change requested with zero target");

    // An evaluate beat occupies the block for the next cycle
    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == lpfs_pkg::MODE_EVAL) |=> !s_tready)
        else $error("input ready right after an evaluate beat");

    // Pad bit stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[lpfs_pkg::M_DATA_W-1])
        else $error("m_tdata pad bit set");

endmodule

bind load_proportional_freq_select_core lpfs_checker u_lpfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
